### hdl/can_signal_table_decoder_unit_assert.svh
// ----------------------------------------------------------------------------
// CAN signal table decoder assertion macros
// Concurrent check wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef CAN_SIGNAL_TABLE_DECODER_UNIT_ASSERT_SVH
`define CAN_SIGNAL_TABLE_DECODER_UNIT_ASSERT_SVH
`ifndef SYNTH
// property checked on every clock, off during reset
`define CSTD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// antecedent in this cycle implies consequent in the next
`define CSTD_ASSERT_NEXT(lbl, ante, cons, msg) \
  `CSTD_ASSERT(lbl, (ante) |=> (cons), msg)
`else
`define CSTD_ASSERT(lbl, prop, msg)
`define CSTD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### hdl/cstd_pkg.sv
// ----------------------------------------------------------------------------
// CAN signal table decoder package
// Shared sizes, function codes and sequencer states.
// ----------------------------------------------------------------------------
package cstd_pkg;

  localparam int unsigned MaxMessagesDef  = 32;
  localparam int unsigned MaxSignalsDef   = 4;
  localparam int unsigned MaxFieldBitsDef = 32;

  // function codes of an input transaction
  localparam logic [1:0] FUNC_DECODE = 2'd0;
  localparam logic [1:0] FUNC_WR_MSG = 2'd1;
  localparam logic [1:0] FUNC_WR_SIG = 2'd2;

  localparam int unsigned MsgWordW = 32;  // id 31..3, count 2..0
  localparam int unsigned SigWordW = 74;  // layout 73..56, factor 55..32, offset 31..0

  localparam logic signed [57:0] PHYS_MAX = {1'b0, {57{1'b1}}};
  localparam logic signed [57:0] PHYS_MIN = {1'b1, {57{1'b0}}};
  localparam logic [58:0]        PROD_CAP = {1'b1, 58'd0};

  typedef enum logic [3:0] {
    S_IDLE,
    S_MSCAN,
    S_MCHK,
    S_SRD,
    S_EXT,
    S_MUL_LO,
    S_MUL_HI,
    S_CAP,
    S_SUM,
    S_OUT
  } state_e;

endpackage

### hdl/cstd_ram.sv
// ----------------------------------------------------------------------------
// CAN signal table decoder RAM
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cstd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/can_signal_table_decoder_unit.sv
// ----------------------------------------------------------------------------
// CAN signal table decoder unit
// Table-driven frame decoder: ID search over message RAM, then per-signal
// bit-field extraction and Q16 scaling from signal RAM.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | content
//  --------+-----------+----------------------+------------------------------
//  in      | sink      | in_valid_i/in_stall_o | func, id, payload, table data
//  cfg     | sink      | cfg_valid_i/ready_o  | message_count (6 bit)
//  out     | source    | out_valid_o/stall_i  | code, raw, phys, byte, last
//
//  Table writes are stored when accepted. A decode transaction starts an ID
//  search over the entries up to the hit or the end, one message RAM read per
//  cycle; each signal then goes through read, extract, multiply low and high,
//  cap, sum and output, each result waiting under out_stall_i. The input is
//  stalled until the last result is taken. Both RAMs power up undefined; no
//  clearing pass. Reset clears only sequencer and count.
// ----------------------------------------------------------------------------
`include "can_signal_table_decoder_unit_assert.svh"

module can_signal_table_decoder_unit
  import cstd_pkg::*;
#(
  parameter int unsigned MAX_MESSAGES   = MaxMessagesDef,
  parameter int unsigned MAX_SIGNALS    = MaxSignalsDef,
  parameter int unsigned MAX_FIELD_BITS = MaxFieldBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         func_i,
  input  logic [28:0]        can_id_i,
  input  logic [63:0]        payload_i,
  input  logic [4:0]         entry_index_i,
  input  logic [1:0]         signal_slot_i,
  input  logic [2:0]         signal_count_i,
  input  logic [4:0]         signal_code_i,
  input  logic [5:0]         start_bit_i,
  input  logic [5:0]         bit_length_i,
  input  logic               msb_first_i,
  input  logic [23:0]        factor_q16_i,
  input  logic signed [31:0] offset_q16_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [5:0]         cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [4:0]         out_signal_code_o,
  output logic [31:0]        raw_value_o,
  output logic signed [57:0] phys_q16_o,
  output logic [7:0]         byte_value_o,
  output logic               last_o
);

  localparam int unsigned MAW   = (MAX_MESSAGES > 1) ? $clog2(MAX_MESSAGES) : 1;
  localparam int unsigned CW    = $clog2(MAX_MESSAGES + 1);
  localparam int unsigned SDEP  = MAX_MESSAGES * MAX_SIGNALS;
  localparam int unsigned SAW   = (SDEP > 1) ? $clog2(SDEP) : 1;
  localparam int unsigned SCW   = $clog2(MAX_SIGNALS + 1);
  localparam int unsigned RAW_W = MAX_FIELD_BITS;

  state_e state_q, state_d;

  logic [5:0]     msg_count_q;
  logic [CW-1:0]  idx_q, idx_d, limit;
  logic [MAW-1:0] hit_q, hit_d;
  logic [SCW-1:0] cnt_q, cnt_d, slot_q, slot_d, cnt_rd;

  logic [28:0]        id_q;
  logic [63:0]        pl_q;
  logic [4:0]         code_q;
  logic [RAW_W-1:0]   raw_q, raw_d;
  logic [23:0]        factor_q;
  logic signed [31:0] offset_q;
  logic [55:0]        plo_q, phi_q;
  logic [58:0]        prod_q, prod_d;
  logic signed [57:0] phys_q, phys_d;

  logic in_acc, out_acc, idx_end;

  // ---------------------------------------------------------------- memories
  logic                msg_we, msg_re, sig_we, sig_re;
  logic [MAW-1:0]      msg_waddr, msg_raddr;
  logic [SAW-1:0]      sig_waddr, sig_raddr;
  logic [MsgWordW-1:0] msg_rdata;
  logic [SigWordW-1:0] sig_rdata;

  cstd_ram #(.WIDTH(MsgWordW), .DEPTH(MAX_MESSAGES)) u_msg_ram (
    .clk_i   (clk_i),
    .we_i    (msg_we),
    .waddr_i (msg_waddr),
    .wdata_i ({can_id_i, signal_count_i}),
    .re_i    (msg_re),
    .raddr_i (msg_raddr),
    .rdata_o (msg_rdata)
  );

  cstd_ram #(.WIDTH(SigWordW), .DEPTH(SDEP)) u_sig_ram (
    .clk_i   (clk_i),
    .we_i    (sig_we),
    .waddr_i (sig_waddr),
    .wdata_i ({signal_code_i, start_bit_i, bit_length_i, msb_first_i,
                factor_q16_i, offset_q16_i}),
    .re_i    (sig_re),
    .raddr_i (sig_raddr),
    .rdata_o (sig_rdata)
  );

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // entries searched: message_count capped at table size
  always_comb begin
    if ({3'd0, msg_count_q} > 9'(MAX_MESSAGES)) begin
      limit = CW'(MAX_MESSAGES);
    end else begin
      limit = CW'(msg_count_q);
    end
  end

  // stored signal count capped at MAX_SIGNALS
  always_comb begin
    if ({2'd0, msg_rdata[2:0]} > 5'(MAX_SIGNALS)) begin
      cnt_rd = SCW'(MAX_SIGNALS);
    end else begin
      cnt_rd = SCW'(msg_rdata[2:0]);
    end
  end

  assign idx_end = (idx_q + 1'b1) == limit;

  // writes only from idle; out-of-range slots are dropped
  assign msg_we    = in_acc && (func_i == FUNC_WR_MSG) &&
                     ({4'd0, entry_index_i} < 9'(MAX_MESSAGES));
  assign sig_we    = in_acc && (func_i == FUNC_WR_SIG) &&
                     ({4'd0, entry_index_i} < 9'(MAX_MESSAGES)) &&
                     ({3'd0, signal_slot_i} < 5'(MAX_SIGNALS));
  assign msg_waddr = MAW'(entry_index_i);
  assign sig_waddr = SAW'(entry_index_i) * SAW'(MAX_SIGNALS) + SAW'(signal_slot_i);

  // ------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && (func_i == FUNC_DECODE) && (limit != '0)) begin
          state_d = S_MSCAN;
        end
      end
      S_MSCAN: state_d = S_MCHK;
      S_MCHK: begin
        if (msg_rdata[31:3] == id_q) begin
          state_d = (cnt_rd == '0) ? S_IDLE : S_SRD;
        end else if (idx_end) begin
          state_d = S_IDLE;
        end
      end
      S_SRD:    state_d = S_EXT;
      S_EXT:    state_d = S_MUL_LO;
      S_MUL_LO: state_d = S_MUL_HI;
      S_MUL_HI: state_d = S_CAP;
      S_CAP:    state_d = S_SUM;
      S_SUM:    state_d = S_OUT;
      S_OUT: begin
        if (out_acc) begin
          state_d = last_o ? S_IDLE : S_SRD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- outputs
  always_comb begin
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    msg_re      = 1'b0;
    msg_raddr   = idx_q[MAW-1:0];
    sig_re      = 1'b0;
    idx_d       = idx_q;
    hit_d       = hit_q;
    cnt_d       = cnt_q;
    slot_d      = slot_q;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        idx_d      = '0;
      end
      S_MSCAN: begin
        msg_re = 1'b1;
      end
      S_MCHK: begin
        // keep one read in flight: fetch the next entry while checking this one
        msg_re    = !idx_end;
        msg_raddr = MAW'(idx_q + 1'b1);
        idx_d     = idx_q + 1'b1;
        hit_d     = idx_q[MAW-1:0];
        cnt_d     = cnt_rd;
        slot_d    = '0;
      end
      S_SRD: begin
        sig_re = 1'b1;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_acc) begin
          slot_d = slot_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign sig_raddr   = SAW'(hit_q) * SAW'(MAX_SIGNALS) + SAW'(slot_q);
  assign cfg_ready_o = 1'b1;

  // ------------------------------------------------------- field extraction
  logic [5:0]   lay_start, lay_len;
  logic         lay_msb;
  logic [6:0]   len_c;
  logic [7:0]   shamt;
  logic [127:0] win;

  assign lay_start = sig_rdata[68:63];
  assign lay_len   = sig_rdata[62:57];
  assign lay_msb   = sig_rdata[56];

  always_comb begin
    if ({1'b0, lay_len} > 7'(MAX_FIELD_BITS)) begin
      len_c = 7'(MAX_FIELD_BITS);
    end else begin
      len_c = {1'b0, lay_len};
    end
    // payload sits at bits 127..64; bits below it read as zero
    if (lay_msb) begin
      shamt = 8'd65 + {2'd0, lay_start} - {1'b0, len_c};
    end else begin
      shamt = 8'd64 + {2'd0, lay_start};
    end
    win = {pl_q, 64'd0} >> shamt;
    for (int b = 0; b < RAW_W; b++) begin
      raw_d[b] = win[b] && (b < int'(len_c));
    end
  end

  // ------------------------------------------------------------- scaling
  logic [63:0]  raw64;
  logic [87:0]  prod_full;
  logic signed [59:0] sum;

  assign raw64     = 64'(raw_q);
  assign prod_full = {32'd0, plo_q} + {phi_q, 32'd0};

  always_comb begin
    if (prod_full > 88'(PROD_CAP)) begin
      prod_d = PROD_CAP;
    end else begin
      prod_d = prod_full[58:0];
    end
    sum = $signed({1'b0, prod_q}) + 60'(offset_q);
    if (sum > 60'(PHYS_MAX)) begin
      phys_d = PHYS_MAX;
    end else if (sum < 60'(PHYS_MIN)) begin
      phys_d = PHYS_MIN;
    end else begin
      phys_d = sum[57:0];
    end
  end

  // integer part truncated toward zero
  logic [57:0] mag;
  logic [7:0]  ip_lo;
  assign mag   = phys_q[57] ? (58'd0 - phys_q) : phys_q;
  assign ip_lo = mag[23:16];

  assign out_signal_code_o = code_q;
  assign raw_value_o       = 32'(raw64);
  assign phys_q16_o        = phys_q;
  assign byte_value_o      = phys_q[57] ? (8'd0 - ip_lo) : ip_lo;
  assign last_o            = (SCW'(slot_q + 1'b1) == cnt_q);

  // ------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      msg_count_q <= '0;
      idx_q       <= '0;
      cnt_q       <= '0;
      slot_q      <= '0;
      hit_q       <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      slot_q  <= slot_d;
      hit_q   <= hit_d;
      if (cfg_valid_i && cfg_ready_o) begin
        msg_count_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      id_q <= can_id_i;
      pl_q <= payload_i;
    end
    unique case (state_q)
      S_EXT: begin
        raw_q    <= raw_d;
        code_q   <= sig_rdata[73:69];
        factor_q <= sig_rdata[55:32];
        offset_q <= $signed(sig_rdata[31:0]);
      end
      S_MUL_LO: plo_q  <= raw64[31:0] * factor_q;
      S_MUL_HI: phi_q  <= raw64[63:32] * factor_q;
      S_CAP:    prod_q <= prod_d;
      S_SUM:    phys_q <= phys_d;
      default: ;
    endcase
  end

  // ------------------------------------------------------------ assertions
  `CSTD_ASSERT(a_no_accept_while_out, !(out_valid_o && !in_stall_o), "input open during result")
  `CSTD_ASSERT_NEXT(a_last_frees_input, out_acc && last_o, !in_stall_o, "input not freed after last")
  `CSTD_ASSERT_NEXT(a_empty_table_idle, in_acc && (func_i == FUNC_DECODE) && (limit == '0), !in_stall_o && !out_valid_o, "empty search not idle")

endmodule
